// File: rtl/core/bdvx_pkg.sv
// ----------------------------------------------------------------------------
// Bulk dump voice extractor - shared definitions
// Frame layout positions, expected header bytes and status codes.
// ----------------------------------------------------------------------------
package bdvx_pkg;

  localparam int unsigned PosW      = 13;
  localparam int unsigned OffsetW   = 7;
  localparam int unsigned VoiceSelW = 5;

  localparam logic [PosW-1:0] FrameLen    = 13'd4104;
  localparam logic [PosW-1:0] PosStart    = 13'd0;
  localparam logic [PosW-1:0] PosVendor   = 13'd1;
  localparam logic [PosW-1:0] PosType     = 13'd3;
  localparam logic [PosW-1:0] PosData     = 13'd6;
  localparam logic [PosW-1:0] PosChecksum = 13'd4102;
  localparam logic [PosW-1:0] PosEnd      = 13'd4103;

  localparam logic [7:0] ByteStart  = 8'hf0;
  localparam logic [7:0] ByteVendor = 8'h43;
  localparam logic [7:0] ByteType   = 8'h09;
  localparam logic [7:0] ByteEnd    = 8'hf7;

  // Bit positions within the header fault flags.
  localparam int unsigned FaultStart  = 0;
  localparam int unsigned FaultVendor = 1;
  localparam int unsigned FaultEnd    = 2;
  localparam int unsigned FaultType   = 3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SIZE     = 3'd1,
    ST_START    = 3'd2,
    ST_VENDOR   = 3'd3,
    ST_END      = 3'd4,
    ST_TYPE     = 3'd5,
    ST_CHECKSUM = 3'd6
  } status_t;

  typedef enum logic {
    KIND_VOICE  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

endpackage

// File: rtl/core/bdvx_if.sv
// ----------------------------------------------------------------------------
// Bulk dump voice extractor - stream channels
// Valid/ready channels for incoming dump bytes and outgoing result words.
// ----------------------------------------------------------------------------
interface bdvx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface bdvx_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] voice_byte;
  logic [6:0] voice_offset;
  logic [2:0] status;

  modport source (output valid, output result_kind, output voice_byte,
                  output voice_offset, output status, input ready);
  modport sink   (input valid, input result_kind, input voice_byte,
                  input voice_offset, input status, output ready);
endinterface

// File: rtl/core/bulk_dump_voice_extract_check.sv
// ----------------------------------------------------------------------------
// Bulk dump voice extractor and checker
// Streams a 32-voice bulk dump, emits the selected voice and a frame status.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one dump byte per word, with frame_end set on the last byte.
//   out_ch carries result words: a voice word (result_kind 0) for each of the
//   128 data bytes of the selected voice, with its offset, and a status word
//   (result_kind 1) when the frame-end byte is taken.
//   cfg_we/cfg_wdata set the voice to extract; write it between frames.
//   Every byte is handled by the frame tracker as it is accepted, and any result
//   word is held in a single output register, so out_ch.valid rises in the cycle
//   after acceptance; throughput is one byte per cycle while out_ch keeps up.
//   While a result word waits, a new byte is still taken when the receiver
//   takes the waiting word in the same cycle; if the receiver stalls with a
//   word pending, in_ch.ready drops until that word is taken.
//   Voice words precede the verdict, so the receiver drops them on a bad
//   status. Bytes past the nominal frame length are ignored until frame end.
//   Reset clears the frame state, the pending word and the voice select.
// ----------------------------------------------------------------------------
module bulk_dump_voice_extract_check (
  input  logic                          clk,
  input  logic                          rst_n,
  bdvx_in_if.sink                       in_ch,
  bdvx_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [bdvx_pkg::VoiceSelW-1:0] cfg_wdata
);
  import bdvx_pkg::*;

  logic [VoiceSelW-1:0] voice_sel_r;
  logic [PosW-1:0]      pos_r, pos_nxt;
  logic [6:0]           sum_r, sum_nxt;
  logic [7:0]           chk_r, chk_nxt;
  logic [3:0]           faults_r, faults_nxt;

  logic                 out_valid_r;
  kind_t                kind_r, kind_nxt;
  logic [7:0]           vbyte_r, vbyte_nxt;
  logic [OffsetW-1:0]   voff_r, voff_nxt;
  status_t              status_r, status_nxt;

  logic                 accept;
  logic                 in_frame;
  logic                 in_data;
  logic [PosW-1:0]      data_idx;
  logic                 emit_voice;
  logic                 emit_any;
  logic [6:0]           expect_sum;
  logic [7:0]           b;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    in_frame   = pos_r < FrameLen;
    in_data    = in_frame && (pos_r >= PosData) && (pos_r < PosChecksum);
    data_idx   = pos_r - PosData;
    emit_voice = in_data && (data_idx[OffsetW +: VoiceSelW] == voice_sel_r);

    faults_nxt = faults_r;
    chk_nxt    = chk_r;
    sum_nxt    = sum_r;
    pos_nxt    = pos_r;
    if (in_frame) begin
      if (pos_r == PosStart && b != ByteStart) faults_nxt[FaultStart] = 1'b1;
      if (pos_r == PosVendor && b != ByteVendor) faults_nxt[FaultVendor] = 1'b1;
      if (pos_r == PosType && b != ByteType) faults_nxt[FaultType] = 1'b1;
      if (pos_r == PosEnd && b != ByteEnd) faults_nxt[FaultEnd] = 1'b1;
      if (pos_r == PosChecksum) chk_nxt = b;
      if (in_data) sum_nxt = sum_r + b[6:0];
      pos_nxt = pos_r + 13'd1;
    end

    // The expected checksum is the two's complement of the sum, seven bits.
    expect_sum = 7'd0 - sum_nxt;
    if (pos_r != PosEnd)                   status_nxt = ST_SIZE;
    else if (faults_nxt[FaultStart])       status_nxt = ST_START;
    else if (faults_nxt[FaultVendor])      status_nxt = ST_VENDOR;
    else if (faults_nxt[FaultEnd])         status_nxt = ST_END;
    else if (faults_nxt[FaultType])        status_nxt = ST_TYPE;
    else if (chk_nxt != {1'b0, expect_sum}) status_nxt = ST_CHECKSUM;
    else                                   status_nxt = ST_OK;

    emit_any = in_ch.frame_end || emit_voice;
    if (in_ch.frame_end) begin
      kind_nxt  = KIND_STATUS;
      vbyte_nxt = 8'd0;
      voff_nxt  = '0;
      // A new frame starts cleanly after the status word.
      pos_nxt    = '0;
      sum_nxt    = '0;
      chk_nxt    = '0;
      faults_nxt = '0;
    end else begin
      kind_nxt   = KIND_VOICE;
      vbyte_nxt  = b;
      voff_nxt   = data_idx[OffsetW-1:0];
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_sel_r <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      chk_r       <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) voice_sel_r <= cfg_wdata;
      if (accept) begin
        pos_r       <= pos_nxt;
        sum_r       <= sum_nxt;
        chk_r       <= chk_nxt;
        faults_r    <= faults_nxt;
        out_valid_r <= emit_any;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_any) begin
      kind_r   <= kind_nxt;
      vbyte_r  <= vbyte_nxt;
      voff_r   <= voff_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = kind_r;
  assign out_ch.voice_byte   = vbyte_r;
  assign out_ch.voice_offset = voff_r;
  assign out_ch.status       = status_r;

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= FrameLen)
    else $error("byte position ran past the frame length");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.frame_end |=> pos_r == '0 && sum_r == '0 && faults_r == '0)
    else $error("frame state not cleared after frame end");

  a_status_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_STATUS |-> vbyte_r == 8'd0 && voff_r == '0)
    else $error("status word carries voice fields");

  a_voice_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_VOICE |-> status_r == ST_OK)
    else $error("voice word carries a status");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(vbyte_r)
                                    && $stable(status_r))
    else $error("pending result word lost under stall");

endmodule
